### rtl/cfst_pkg.sv
// ----------------------------------------------------------------------------
// cfst_pkg
// shared constants, word types and state encoding for the can id statistics
// table
// ----------------------------------------------------------------------------
package cfst_pkg;

  // table size and derived widths
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // command codes
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [28:0] frame_id;
    logic        frame_ext;
    logic        frame_rtr;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [7:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [28:0] entry_id;
    logic        entry_ext;
    logic        entry_rtr;
    logic [3:0]  entry_len;
    logic [63:0] entry_data;
    logic [31:0] entry_count;
    logic [7:0]  entries_in_use;
    logic [31:0] frames_total;
  } out_word_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] count;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // memory access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ent_t             wr_data;
  } ram_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RD_ISSUE,
    S_RD_DATA
  } fsm_t;

endpackage

### rtl/can_frame_id_statistics_table_top.sv
// ----------------------------------------------------------------------------
// can_frame_id_statistics_table_top
// per-identifier statistics table for received can frames: update, insert,
// read back and clear, with a frame total counter
// ----------------------------------------------------------------------------
//
//  channel  ports                    direction  handshake
//  -------  -----------------------  ---------  ------------------------------
//  input    start, busy, in_word     in         word taken when start && !busy
//  result   out_valid, out_word      out        one-cycle strobe, no back-pressure
//
//  a received frame keeps busy high while the table is searched from entry 0:
//    on a match with entry k it stops there, and on an insert or drop it stops
//    once all entries in use were compared; one entry is compared per cycle,
//    set by the single read port of the table memory
//  a read keeps busy high for the index check and, on a hit, the entry fetch;
//    clear and the unused command code are answered without going busy
//  the result word is strobed in the first cycle with busy low again, or in
//    the cycle right after the accepting edge for commands that do not go busy
//  reset: synchronous active-low rst_n clears the counters and the sequencer;
//    table contents are not cleared, entries at or above entries_in_use are
//    never read
//  the receiver cannot stall: each result is valid for exactly one cycle
//
module can_frame_id_statistics_table_top
  import cfst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  ram_req_t ram_req;
  ent_t     ram_rdata;

  // sequencer: search walk, read-modify-write, counters, result register
  cfst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // table memory: id, flags, length, payload and count per entry
  cfst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rdata)
  );

endmodule

### rtl/cfst_ram.sv
// ----------------------------------------------------------------------------
// cfst_ram
// generic single-clock ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module cfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/cfst_ctrl.sv
// ----------------------------------------------------------------------------
// cfst_ctrl
// command sequencer: linear table search with read-modify-write, entry
// reads, counters and the result register
// ----------------------------------------------------------------------------
module cfst_ctrl
  import cfst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word,
  output ram_req_t  ram_req,
  input  ent_t      ram_rdata
);

  fsm_t             state_r, state_nxt;
  in_word_t         item_r, item_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [31:0]      total_r, total_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic      accept;
  logic      match;
  logic      scan_more;
  logic      rd_hit;
  out_word_t res;

  assign accept    = start && (state_r == S_IDLE);
  assign match     = cmp_vld_r && (ram_rdata.id == item_r.frame_id);
  assign scan_more = scan_r < used_r;
  assign rd_hit    = item_r.read_index < 8'(used_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_word.command)
            CMD_FRAME: state_nxt = S_SCAN;
            CMD_READ:  state_nxt = S_RD_ISSUE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (match || !scan_more) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        state_nxt = rd_hit ? S_RD_DATA : S_IDLE;
      end
      S_RD_DATA: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt      = item_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_req       = '0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_word;
          case (in_word.command)
            CMD_FRAME: begin
              total_nxt = total_r + 32'd1;
              scan_nxt  = '0;
            end
            CMD_READ: begin
            end
            CMD_CLEAR: begin
              used_nxt      = '0;
              total_nxt     = '0;
              out_valid_nxt = 1'b1;
              res.status    = ST_CLEARED;
            end
            default: begin
              out_valid_nxt = 1'b1;
              res.status    = ST_MISS;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          // keep stored id and flags, refresh payload, bump count
          ram_req.wr_en         = 1'b1;
          ram_req.wr_addr       = cmp_idx_r;
          ram_req.wr_data.id    = ram_rdata.id;
          ram_req.wr_data.ext   = ram_rdata.ext;
          ram_req.wr_data.rtr   = ram_rdata.rtr;
          ram_req.wr_data.len   = item_r.frame_len;
          ram_req.wr_data.data  = item_r.frame_data;
          ram_req.wr_data.count = ram_rdata.count + 32'd1;
          out_valid_nxt         = 1'b1;
          res.status            = ST_UPDATED;
        end else if (scan_more) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = scan_r[IDX_W-1:0];
          cmp_vld_nxt     = 1'b1;
          cmp_idx_nxt     = scan_r[IDX_W-1:0];
          scan_nxt        = scan_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          if (used_r < CNT_W'(TABLE_ENTRIES)) begin
            ram_req.wr_en         = 1'b1;
            ram_req.wr_addr       = used_r[IDX_W-1:0];
            ram_req.wr_data.id    = item_r.frame_id;
            ram_req.wr_data.ext   = item_r.frame_ext;
            ram_req.wr_data.rtr   = item_r.frame_rtr;
            ram_req.wr_data.len   = item_r.frame_len;
            ram_req.wr_data.data  = item_r.frame_data;
            ram_req.wr_data.count = 32'd1;
            used_nxt              = used_r + 1'b1;
            res.status            = ST_INSERTED;
          end else begin
            res.status = ST_DROPPED;
          end
        end
      end
      S_RD_ISSUE: begin
        if (rd_hit) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = item_r.read_index[IDX_W-1:0];
        end else begin
          out_valid_nxt = 1'b1;
          res.status    = ST_MISS;
        end
      end
      S_RD_DATA: begin
        out_valid_nxt   = 1'b1;
        res.status      = ST_HIT;
        res.entry_id    = ram_rdata.id;
        res.entry_ext   = ram_rdata.ext;
        res.entry_rtr   = ram_rdata.rtr;
        res.entry_len   = ram_rdata.len;
        res.entry_data  = ram_rdata.data;
        res.entry_count = ram_rdata.count;
      end
      default: begin
      end
    endcase

    res.entries_in_use = 8'(used_nxt);
    res.frames_total   = total_nxt;
    if (out_valid_nxt) begin
      out_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      scan_r      <= scan_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // never read and write the table in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.wr_en && ram_req.rd_en))
    else $error("table read and write in the same cycle");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entries in use beyond table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= used_r))
    else $error("search pointer past entries in use");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_word.command == CMD_CLEAR)) |=>
      (out_valid_r && (out_r.status == ST_CLEARED) && (used_r == '0)))
    else $error("clear not answered in the next cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while a command is still in work");

endmodule

### verif/tb_can_frame_id_statistics_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_frame_id_statistics_table_top
// self-checking bench for the can id statistics table: a scoreboard model of
// the table predicts every result word, directed cases hit the corner
// behaviors, then randomized traffic with random sender gaps runs the scan
// ----------------------------------------------------------------------------
module tb_can_frame_id_statistics_table_top;
  import cfst_pkg::*;

  // command code with no function, answered as a read miss
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int GAP_MAX      = 5;
  // longest quiet stretch: a full scan plus the longest sender gap, many times over
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 4;
  localparam int RANDOM_WORDS = 450;
  localparam int POOL_SIZE    = 16;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  can_frame_id_statistics_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // scoreboard copy of the table
  // ---------------------------------------------------------------------------
  logic [28:0] tbl_id    [TABLE_ENTRIES];
  logic        tbl_ext   [TABLE_ENTRIES];
  logic        tbl_rtr   [TABLE_ENTRIES];
  logic [3:0]  tbl_len   [TABLE_ENTRIES];
  logic [63:0] tbl_data  [TABLE_ENTRIES];
  logic [31:0] tbl_count [TABLE_ENTRIES];
  int unsigned ids_used    = 0;
  logic [31:0] frames_seen = '0;

  // result words predicted but not yet seen on the output, oldest first
  out_word_t   pending_results[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int status_seen [8];
  bit burst_mode  = 1'b0;

  // apply one accepted word to the scoreboard table and return its result word
  function automatic out_word_t apply_to_table(input in_word_t w);
    out_word_t r;
    int        hit_idx;
    int        k;
    r       = '0;
    hit_idx = -1;
    case (w.command)
      CMD_FRAME: begin
        frames_seen = frames_seen + 32'd1;
        // first match wins, extended flag takes no part
        for (k = 0; k < ids_used; k++) begin
          if (hit_idx < 0 && tbl_id[k] == w.frame_id) hit_idx = k;
        end
        if (hit_idx >= 0) begin
          tbl_len[hit_idx]   = w.frame_len;
          tbl_data[hit_idx]  = w.frame_data;
          tbl_count[hit_idx] = tbl_count[hit_idx] + 32'd1;
          r.status           = ST_UPDATED;
        end else if (ids_used < TABLE_ENTRIES) begin
          tbl_id[ids_used]    = w.frame_id;
          tbl_ext[ids_used]   = w.frame_ext;
          tbl_rtr[ids_used]   = w.frame_rtr;
          tbl_len[ids_used]   = w.frame_len;
          tbl_data[ids_used]  = w.frame_data;
          tbl_count[ids_used] = 32'd1;
          ids_used++;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_DROPPED;
        end
      end
      CMD_READ: begin
        if (w.read_index < ids_used) begin
          r.status      = ST_HIT;
          r.entry_id    = tbl_id[w.read_index];
          r.entry_ext   = tbl_ext[w.read_index];
          r.entry_rtr   = tbl_rtr[w.read_index];
          r.entry_len   = tbl_len[w.read_index];
          r.entry_data  = tbl_data[w.read_index];
          r.entry_count = tbl_count[w.read_index];
        end else begin
          r.status = ST_MISS;
        end
      end
      CMD_CLEAR: begin
        ids_used    = 0;
        frames_seen = '0;
        r.status    = ST_CLEARED;
      end
      default: r.status = ST_MISS;
    endcase
    r.entries_in_use = 8'(ids_used);
    r.frames_total   = frames_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // word builders, unused fields carry random noise
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [28:0] rand_id();
    // half standard 11-bit ids, half extended 29-bit ids
    if ($urandom_range(0, 1)) return 29'($urandom_range(0, 11'h7ff));
    return 29'($urandom);
  endfunction

  function automatic in_word_t frame_word(input logic [28:0] id, input logic ext,
                                          input logic rtr, input logic [3:0] len,
                                          input logic [63:0] data);
    in_word_t w;
    w.command    = CMD_FRAME;
    w.frame_id   = id;
    w.frame_ext  = ext;
    w.frame_rtr  = rtr;
    w.frame_len  = len;
    w.frame_data = data;
    w.read_index = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t random_frame(input logic [28:0] id);
    logic [3:0] len;
    // mostly legal lengths, now and then an oversized code
    if ($urandom_range(0, 9) == 0) len = 4'($urandom_range(9, 15));
    else len = 4'($urandom_range(0, 8));
    return frame_word(id, 1'($urandom), 1'($urandom), len, rand_data());
  endfunction

  function automatic in_word_t cmd_word(input logic [1:0] cmd, input logic [7:0] idx);
    in_word_t w;
    w            = frame_word(29'($urandom), 1'($urandom), 1'($urandom),
                              4'($urandom), rand_data());
    w.command    = cmd;
    w.read_index = idx;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
    // start only drops when a gap follows, so back-to-back words keep it high
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_to_table(w));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  out_word_t oldest;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with none pending, status %0d", out_word.status);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        status_seen[oldest.status]++;
        check_field("status", 64'(oldest.status), 64'(out_word.status));
        check_field("entry_id", 64'(oldest.entry_id), 64'(out_word.entry_id));
        check_field("entry_ext", 64'(oldest.entry_ext), 64'(out_word.entry_ext));
        check_field("entry_rtr", 64'(oldest.entry_rtr), 64'(out_word.entry_rtr));
        check_field("entry_len", 64'(oldest.entry_len), 64'(out_word.entry_len));
        check_field("entry_data", oldest.entry_data, out_word.entry_data);
        check_field("entry_count", 64'(oldest.entry_count), 64'(out_word.entry_count));
        check_field("entries_in_use", 64'(oldest.entries_in_use),
                    64'(out_word.entries_in_use));
        check_field("frames_total", 64'(oldest.frames_total),
                    64'(out_word.frames_total));
      end
    end
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner behaviors on a small table
  task automatic test_directed();
    // empty table: both ends of the index range miss, unused code misses
    send_word(cmd_word(CMD_READ, 8'd0));
    send_word(cmd_word(CMD_READ, 8'hff));
    send_word(cmd_word(CMD_UNUSED, 8'd0));
    // smallest and largest identifiers, payload extremes
    send_word(frame_word(29'd0, 1'b0, 1'b0, 4'd0, 64'd0));
    send_word(frame_word(29'h1fffffff, 1'b1, 1'b1, 4'd15, '1));
    // same id with other flags: update keeps stored flags
    send_word(frame_word(29'h1fffffff, 1'b0, 1'b0, 4'd8, 64'h0123_4567_89ab_cdef));
    send_word(frame_word(29'h7ff, 1'b0, 1'b1, 4'd8, 64'hfedc_ba98_7654_3210));
    send_word(frame_word(29'h7ff, 1'b1, 1'b0, 4'd3, 64'h5555_aaaa_5555_aaaa));
    send_word(frame_word(29'h7ff, 1'b1, 1'b1, 4'd9, 64'haaaa_5555_aaaa_5555));
    send_word(cmd_word(CMD_READ, 8'd0));
    send_word(cmd_word(CMD_READ, 8'd1));
    send_word(cmd_word(CMD_READ, 8'd2));
    // index equal to entries in use, and far beyond
    send_word(cmd_word(CMD_READ, 8'd3));
    send_word(cmd_word(CMD_READ, 8'hff));
    // clear resets counters only, stale entries stay hidden
    send_word(cmd_word(CMD_CLEAR, 8'd0));
    send_word(cmd_word(CMD_READ, 8'd0));
    send_word(frame_word(29'd5, 1'b0, 1'b0, 4'd1, 64'h42));
    send_word(cmd_word(CMD_READ, 8'd0));
    send_word(cmd_word(CMD_UNUSED, 8'hff));
    send_word(cmd_word(CMD_READ, 8'd0));
    send_word(cmd_word(CMD_CLEAR, 8'hff));
    send_word(cmd_word(CMD_CLEAR, 8'd0));
  endtask

  // fill every entry, overflow, then touch both ends of the table
  task automatic test_full_table();
    int k;
    send_word(cmd_word(CMD_CLEAR, 8'($urandom)));
    // low bits carry the slot number so ids are distinct
    for (k = 0; k < TABLE_ENTRIES; k++)
      send_word(random_frame({23'($urandom), 6'(k)}));
    // new ids are dropped but still counted
    for (k = 0; k < 4; k++) send_word(random_frame(rand_id()));
    send_word(random_frame(tbl_id[TABLE_ENTRIES-1]));
    send_word(random_frame(tbl_id[0]));
    send_word(cmd_word(CMD_READ, 8'd0));
    send_word(cmd_word(CMD_READ, 8'(TABLE_ENTRIES - 1)));
    send_word(cmd_word(CMD_READ, 8'(TABLE_ENTRIES)));
    send_word(cmd_word(CMD_READ, 8'hff));
  endtask

  // mixed traffic over a small id pool so updates dominate the frames
  task automatic test_random_traffic(input int n_words);
    logic [28:0] pool [POOL_SIZE];
    int          k;
    int          pick;
    for (k = 0; k < POOL_SIZE; k++) pool[k] = rand_id();
    for (k = 0; k < n_words; k++) begin
      // switch between back-to-back bursts and gappy stretches
      if (k % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) pool[$urandom_range(0, POOL_SIZE-1)] = rand_id();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 9) < 7) send_word(random_frame(pool[$urandom_range(0, POOL_SIZE-1)]));
        else send_word(random_frame(rand_id()));
      end else if (pick < 95) begin
        // mostly valid indexes plus the first one past the end
        if ($urandom_range(0, 4) == 0) send_word(cmd_word(CMD_READ, 8'($urandom)));
        else send_word(cmd_word(CMD_READ, 8'($urandom_range(0, ids_used))));
      end else if (pick < 97) begin
        send_word(cmd_word(CMD_CLEAR, 8'($urandom)));
      end else begin
        send_word(cmd_word(CMD_UNUSED, 8'($urandom)));
      end
    end
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_table();
    test_random_traffic(RANDOM_WORDS);

    start <= 1'b0;
    // let the last results come home, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d updates, %0d drops on a full table",
             status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_DROPPED]);
    $display("plus %0d read hits, %0d read misses and %0d clears",
             status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_CLEARED]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### can_frame_id_statistics_table_top.f
rtl/cfst_pkg.sv
rtl/cfst_ram.sv
rtl/cfst_ctrl.sv
rtl/can_frame_id_statistics_table_top.sv
verif/tb_can_frame_id_statistics_table_top.sv
